FILE: rtl/core/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [7:0] STAR_BYTE = 8'd42;
  localparam logic [7:0] ANY_BYTE  = 8'd63;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_END     = 2'd3
  } cmd_e_t;

  // Classified item handed from the front to the engine.
  typedef struct packed {
    logic       clr;
    logic       app;
    logic       sub;
    logic       eos;
    logic [7:0] ch;
  } item_t;

endpackage

FILE: rtl/core/wpm_front.sv
// ----------------------------------------------------------------------------
// wpm_front
// Input side: take beats, decode the command and push classified items.
// ----------------------------------------------------------------------------
module wpm_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        cmd,
  input  logic [7:0]        char_in,
  input  logic              q_full,
  output logic              q_push,
  output wpm_pkg::item_t    q_item
);
  import wpm_pkg::*;

  cmd_e_t cmd_dec;

  assign cmd_dec   = cmd_e_t'(cmd);
  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  always_comb begin
    q_item = '0;
    unique case (cmd_dec)
      CMD_CLEAR:   q_item.clr = 1'b1;
      CMD_APPEND: begin
        q_item.app = 1'b1;
        q_item.ch  = char_in;
      end
      CMD_SUBJECT: begin
        q_item.sub = 1'b1;
        q_item.ch  = char_in;
      end
      CMD_END:     q_item.eos = 1'b1;
      default:     q_item = '0;
    endcase
  end

endmodule

FILE: rtl/core/wpm_fifo.sv
// ----------------------------------------------------------------------------
// wpm_fifo
// Short flop queue between the front and the engine.
// ----------------------------------------------------------------------------
module wpm_fifo #(
  parameter int DEPTH = wpm_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wpm_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output wpm_pkg::item_t rd_item
);
  import wpm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: rtl/core/wpm_engine.sv
// ----------------------------------------------------------------------------
// wpm_engine
// Pattern store, live-position vector and result register.
// ----------------------------------------------------------------------------
module wpm_engine #(
  parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  wpm_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic           matched,
  output logic           pattern_overflow
);
  import wpm_pkg::*;

  localparam int N      = PATTERN_MAX + 1;
  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [7:0]             pat_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] vld_r, vld_nxt;
  logic [PATTERN_MAX-1:0] star_r, star_nxt;
  logic [PATTERN_MAX-1:0] any_r, any_nxt;
  logic [N-1:0]           end_r, end_nxt;   // one-hot pattern length
  logic [N-1:0]           live_r, live_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   matched_r, ovf_out_r;

  logic                   full;
  logic                   do_app;
  logic                   is_star, is_any;
  logic [PATTERN_MAX-1:0] step;
  logic [N-1:0]           seed;

  assign full    = end_r[PATTERN_MAX];
  assign q_pop   = q_valid & (~q_item.eos | ~out_valid_r | out_tready);
  assign do_app  = q_item.app & ~full;
  assign is_star = (q_item.ch == STAR_BYTE);
  assign is_any  = (q_item.ch == ANY_BYTE);

  // Pattern bookkeeping.
  always_comb begin
    vld_nxt  = vld_r;
    star_nxt = star_r;
    any_nxt  = any_r;
    end_nxt  = end_r;
    ovf_nxt  = ovf_r;
    if (q_item.clr) begin
      vld_nxt  = '0;
      star_nxt = '0;
      any_nxt  = '0;
      end_nxt  = N'(1);
      ovf_nxt  = 1'b0;
    end else if (do_app) begin
      vld_nxt  = vld_r | end_r[PATTERN_MAX-1:0];
      star_nxt = star_r | (end_r[PATTERN_MAX-1:0] & {PATTERN_MAX{is_star}});
      any_nxt  = any_r | (end_r[PATTERN_MAX-1:0] & {PATTERN_MAX{is_any}});
      end_nxt  = end_r << 1;
    end else if (q_item.app) begin
      ovf_nxt  = 1'b1;
    end
  end

  // Per-position step on a subject byte, all positions in parallel.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      step[i] = live_r[i] & vld_r[i] & ~star_r[i] &
                (any_r[i] | (pat_r[i] == q_item.ch));
    end
  end

  always_comb begin
    if (q_item.sub) begin
      seed = {1'b0, live_r[PATTERN_MAX-1:0] & star_r} | {step, 1'b0};
    end else begin
      seed = N'(1);
    end
  end

  // Close over stars as a prefix scan: c[j] = g[j] | p[j] & c[j-1].
  always_comb begin
    logic [N-1:0] g, p, g_t, p_t;
    int           d;
    g = seed;
    p = {star_nxt, 1'b0};
    for (int lv = 0; lv < LEVELS; lv++) begin
      d   = 1 << lv;
      g_t = g;
      p_t = p;
      for (int j = 0; j < N; j++) begin
        if (j >= d) begin
          g[j] = g_t[j] | (p_t[j] & g_t[j-d]);
          p[j] = p_t[j] & p_t[j-d];
        end
      end
    end
    live_nxt = g;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && q_item.eos) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      star_r      <= '0;
      any_r       <= '0;
      end_r       <= N'(1);
      live_r      <= N'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        vld_r  <= vld_nxt;
        star_r <= star_nxt;
        any_r  <= any_nxt;
        end_r  <= end_nxt;
        live_r <= live_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.eos) begin
      matched_r <= |(live_r & end_r);
      ovf_out_r <= ovf_r;
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (q_pop && do_app && end_r[i]) begin
        pat_r[i] <= q_item.ch;
      end
    end
  end

  assign out_tvalid       = out_valid_r;
  assign matched          = matched_r;
  assign pattern_overflow = ovf_out_r;

endmodule

FILE: rtl/core/wildcard_pattern_matcher_unit.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit
// Glob-style whole-string matcher ('*' any run, '?' any byte) on streams.
// ----------------------------------------------------------------------------
// Load a pattern with append beats (in_tuser = 1), then stream subject bytes
// (in_tuser = 2) and close each subject with an end beat (in_tuser = 3); the
// end beat returns one result beat with matched and pattern_overflow, and the
// next subject is checked against the same pattern. A clear beat
// (in_tuser = 0) empties the pattern and the overflow flag; any append or
// clear also restarts the subject in progress. Up to PATTERN_MAX pattern bytes
// are kept; further appends are dropped and flag overflow until the next
// clear. The block takes one beat every clock cycle while in_tready is high;
// each subject byte updates all pattern positions at once, with stars closed
// by a log-depth prefix scan. With nothing queued ahead of it, an end beat
// passes through the queue entry and then the result register before it
// raises out_tvalid. Input beats are held off only when the four-entry queue
// fills, which happens only while a result waits on out_tready, the next end
// beat sits at the queue head, and further beats of any kind pile up behind
// it.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_unit #(
  parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] char_in
  input  logic [1:0] in_tuser,    // [1:0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import wpm_pkg::*;

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_wr_item, q_rd_item;
  logic  matched, pattern_overflow;

  // Decode commands and push them into the queue.
  wpm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (in_tuser),
    .char_in   (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  // Decouple intake from the engine and the result handshake.
  wpm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_item   (q_rd_item)
  );

  // Hold the pattern, advance the live vector, register results.
  wpm_engine #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_rd_item),
    .q_pop            (q_pop),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

  assign out_tdata = {6'b0, pattern_overflow, matched};

endmodule
